[hw/rtl/lrpg_pkg.sv]
// ----------------------------------------------------------------------------
// lrpg_pkg: shared types and constants
// Types and fixed constants of the polynomial logistic-regression step.
// ----------------------------------------------------------------------------
package lrpg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 6;

  localparam logic signed [31:0] CoeffX1Reset = 32'sd40297642;
  localparam logic signed [31:0] CoeffX3Reset = -32'sd27367831;
  localparam logic signed [31:0] OneQ24       = 32'sd16777216;

  localparam logic [1:0] RegCoeffX1 = 2'd0;
  localparam logic [1:0] RegCoeffX3 = 2'd1;
  localparam logic [1:0] RegCoeffX5 = 2'd2;
  localparam logic [1:0] RegCoeffX7 = 2'd3;

  localparam logic OpTheta  = 1'b0;
  localparam logic OpSample = 1'b1;

  // Request passed from the front to the back through the queue.
  typedef struct packed {
    logic                    op;
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] value;
    logic                    last_in_row;
    logic                    last_in_batch;
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_DOT_ADD,
    ST_POLY,
    ST_POLY_WAIT,
    ST_GRAD,
    ST_GRAD_WAIT,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    else if (v < -80'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
    if (v > 80'sd140737488355327) return 48'sh7fffffffffff;
    else if (v < -80'sd140737488355328) return 48'sh800000000000;
    else return v[47:0];
  endfunction

endpackage

[hw/rtl/logistic_regression_poly_gradient_step.sv]
// ----------------------------------------------------------------------------
// logistic_regression_poly_gradient_step: top level
// One batch of logistic-regression gradient descent with polynomial sigmoid.
// ----------------------------------------------------------------------------
// Channel | Handshake               | Payload
// in      | valid / ready           | op, index, value, last_in_row, last_in_batch
// out     | out_valid / out_ready   | theta_index, theta_value, last_of_run
// cfg     | cfg_we                  | cfg_index, cfg_data
//
// Theta writes and ordinary sample elements are handled in the back end's idle state.
// A row end runs the dot product, the polynomial and the gradient update on
// the single shared 32x32 multiplier.
// A batch end then runs a serial divider for each emitted element and also
// waits while the receiver holds out_ready low.
// Reset is synchronous; it restores coefficients and clears the gradient sums and row count.
// The two-entry request queue lets input continue while the back end stalls.
module logistic_regression_poly_gradient_step #(
  parameter int unsigned MaxFeatures = 64,
  parameter int unsigned MaxRows     = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic               op,
  input  logic [5:0]         index,
  input  logic signed [31:0] value,
  input  logic               last_in_row,
  input  logic               last_in_batch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         theta_index,
  output logic signed [31:0] theta_value,
  output logic               last_of_run,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  lrpg_pkg::req_t in_req, q_in, q_out;
  logic q_full, q_push, q_pop, q_ne;
  logic signed [31:0] c1, c3, c5, c7;

  // Bundle the request fields.
  assign in_req = '{op: op, index: index, value: value,
                    last_in_row: last_in_row, last_in_batch: last_in_batch};

  lrpg_front u_front (
    .clk, .rst, .in_valid(valid), .in_ready(ready), .in_req,
    .q_full, .q_push, .q_data(q_in),
    .cfg_we, .cfg_index, .cfg_data,
    .coeff_x1(c1), .coeff_x3(c3), .coeff_x5(c5), .coeff_x7(c7)
  );

  lrpg_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
  );

  lrpg_back #(.MaxFeatures(MaxFeatures), .MaxRows(MaxRows)) u_back (
    .clk, .rst, .req_valid(q_ne), .req(q_out), .req_pop(q_pop),
    .coeff_x1(c1), .coeff_x3(c3), .coeff_x5(c5), .coeff_x7(c7),
    .out_valid, .out_ready, .out_index(theta_index), .out_value(theta_value),
    .out_last(last_of_run)
  );

endmodule

[hw/rtl/lrpg_queue.sv]
// ----------------------------------------------------------------------------
// lrpg_queue: request queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module lrpg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrpg_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lrpg_pkg::req_t pop_data
);

  lrpg_pkg::req_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd0) |=> count == 2'd1)
    else $error("queue count slip");

endmodule

[hw/rtl/lrpg_back.sv]
// ----------------------------------------------------------------------------
// lrpg_back: sequencer for dot product, polynomial, gradient and update
// Carries out requests one at a time and emits updated theta elements.
// ----------------------------------------------------------------------------
module lrpg_back #(
  parameter int unsigned MaxFeatures = 64,
  parameter int unsigned MaxRows     = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  lrpg_pkg::req_t        req,
  output logic                  req_pop,
  input  logic signed [31:0]    coeff_x1,
  input  logic signed [31:0]    coeff_x3,
  input  logic signed [31:0]    coeff_x5,
  input  logic signed [31:0]    coeff_x7,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            out_index,
  output logic signed [31:0]    out_value,
  output logic                  out_last
);

  localparam int unsigned PosW = $clog2(MaxFeatures + 1);
  localparam int unsigned AW   = $clog2(MaxFeatures);
  localparam int unsigned RowW = $clog2(MaxRows + 1);
  localparam int unsigned QW   = 51;

  // Memories: one write and one registered read each. Valid flags make
  // never-written weights and gradient entries read as zero.
  logic signed [31:0] wmem [MaxFeatures];
  logic signed [47:0] gmem [MaxFeatures];
  logic signed [31:0] zmem [MaxFeatures];
  logic [MaxFeatures-1:0] g_valid;
  logic [MaxFeatures-1:0] w_valid;

  lrpg_pkg::state_t state, state_next;
  logic [PosW-1:0] row_position;
  logic [PosW-1:0] n_cnt;
  logic [PosW-1:0] ptr;
  logic [RowW-1:0] rows_seen;
  logic            batch_end;

  logic signed [31:0] w_rd, z_rd;
  logic               w_rd_valid;
  logic signed [47:0] g_rd;
  logic               g_rd_valid;
  logic signed [47:0] acc_dot;
  logic signed [31:0] x, x2, x3, x5, x7;
  logic signed [41:0] poly;
  logic signed [31:0] c;
  logic [2:0]         pstep;

  // divider
  logic [QW-1:0] dnum, dquot;
  logic [RowW-1:0] drows;
  logic [QW:0] drem;
  logic [5:0]  dcnt;
  logic        dneg;
  logic signed [31:0] w_hold;

  logic [AW-1:0] rd_addr;
  assign rd_addr = ptr[AW-1:0];

  always_ff @(posedge clk) begin
    w_rd <= wmem[rd_addr];
    w_rd_valid <= w_valid[rd_addr];
    z_rd <= zmem[rd_addr];
    g_rd <= gmem[rd_addr];
    g_rd_valid <= g_valid[rd_addr];
  end

  logic signed [47:0] g_eff;
  assign g_eff = g_rd_valid ? g_rd : 48'sd0;

  logic signed [31:0] w_eff;
  assign w_eff = w_rd_valid ? w_rd : 32'sd0;

  // Shared multiplier operands.
  logic signed [31:0] ma, mb;
  always_comb begin
    ma = z_rd;
    mb = w_eff;
    case (pstep)
      3'd0: begin ma = x;  mb = x;  end
      3'd1: begin ma = x2; mb = x;  end
      3'd2: begin ma = x3; mb = x2; end
      3'd3: begin ma = x5; mb = x2; end
      3'd4: begin ma = coeff_x1; mb = x;  end
      3'd5: begin ma = coeff_x3; mb = x3; end
      3'd6: begin ma = coeff_x5; mb = x5; end
      default: begin ma = coeff_x7; mb = x7; end
    endcase
    if (state == lrpg_pkg::ST_DOT_ADD) begin ma = z_rd; mb = w_eff; end
    if (state == lrpg_pkg::ST_GRAD_WAIT) begin ma = c; mb = z_rd; end
  end

  logic signed [63:0] prod_now;
  assign prod_now = ma * mb;

  always_comb begin
    state_next = state;
    req_pop = 1'b0;
    case (state)
      lrpg_pkg::ST_IDLE:
        if (req_valid) begin
          req_pop = 1'b1;
          if (req.op == lrpg_pkg::OpSample && (req.last_in_row || req.last_in_batch))
            state_next = lrpg_pkg::ST_DOT;
        end
      lrpg_pkg::ST_DOT: state_next = (ptr == n_cnt) ? lrpg_pkg::ST_POLY : lrpg_pkg::ST_DOT_ADD;
      lrpg_pkg::ST_DOT_ADD: state_next = lrpg_pkg::ST_DOT;
      lrpg_pkg::ST_POLY: state_next = lrpg_pkg::ST_POLY_WAIT;
      lrpg_pkg::ST_POLY_WAIT:
        state_next = (pstep == 3'd7) ? lrpg_pkg::ST_GRAD : lrpg_pkg::ST_POLY;
      lrpg_pkg::ST_GRAD:
        if (ptr == n_cnt) state_next = batch_end ? lrpg_pkg::ST_UPD : lrpg_pkg::ST_IDLE;
        else state_next = lrpg_pkg::ST_GRAD_WAIT;
      lrpg_pkg::ST_GRAD_WAIT: state_next = lrpg_pkg::ST_GRAD;
      lrpg_pkg::ST_UPD:
        state_next = (ptr == n_cnt) ? lrpg_pkg::ST_IDLE : lrpg_pkg::ST_LOAD;
      lrpg_pkg::ST_LOAD: state_next = lrpg_pkg::ST_DIV;
      lrpg_pkg::ST_DIV: if (dcnt == 6'd0) state_next = lrpg_pkg::ST_EMIT;
      lrpg_pkg::ST_EMIT: if (out_ready) state_next = lrpg_pkg::ST_UPD;
      default: state_next = lrpg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lrpg_pkg::ST_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == lrpg_pkg::ST_EMIT);

  logic [RowW-1:0] rows_div;
  assign rows_div = (rows_seen == '0) ? RowW'(1) : rows_seen;

  logic signed [79:0] newt;
  always_comb begin
    newt = 80'(w_hold) + (dneg ? -80'(signed'({1'b0, dquot})) : 80'(signed'({1'b0, dquot})));
  end

  logic [QW:0] dtrial;
  assign dtrial = {drem[QW-1:0], dnum[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      rows_seen    <= '0;
      g_valid      <= '0;
      w_valid      <= '0;
      ptr          <= '0;
      pstep        <= 3'd0;
    end else begin
      case (state)
        lrpg_pkg::ST_IDLE:
          if (req_valid) begin
            if (req.op == lrpg_pkg::OpTheta) begin
              if (32'(req.index) < MaxFeatures) begin
                wmem[req.index[AW-1:0]] <= req.value;
                w_valid[req.index[AW-1:0]] <= 1'b1;
              end
            end else begin
              logic [PosW-1:0] np;
              np = row_position;
              if (row_position < PosW'(MaxFeatures)) begin
                zmem[row_position[AW-1:0]] <= req.value;
                np = row_position + PosW'(1);
              end
              row_position <= np;
              if (req.last_in_row || req.last_in_batch) begin
                n_cnt <= np;
                batch_end <= req.last_in_batch;
                ptr <= '0;
                acc_dot <= '0;
                row_position <= '0;
              end
            end
          end
        lrpg_pkg::ST_DOT: if (ptr != n_cnt) ptr <= ptr + PosW'(1);
        lrpg_pkg::ST_DOT_ADD: acc_dot <= acc_dot + 48'(prod_now >>> 24);
        lrpg_pkg::ST_POLY: begin
          if (pstep == 3'd0) begin
            x <= lrpg_pkg::sat32(80'(acc_dot >>> 3));
            poly <= '0;
          end
        end
        lrpg_pkg::ST_POLY_WAIT: begin
          pstep <= pstep + 3'd1;
          case (pstep)
            3'd0: x2 <= lrpg_pkg::sat32(80'(prod_now >>> 24));
            3'd1: x3 <= lrpg_pkg::sat32(80'(prod_now >>> 24));
            3'd2: x5 <= lrpg_pkg::sat32(80'(prod_now >>> 24));
            3'd3: x7 <= lrpg_pkg::sat32(80'(prod_now >>> 24));
            3'd4, 3'd5, 3'd6: poly <= poly + 42'(prod_now >>> 24);
            default: begin
              c <= lrpg_pkg::sat32(80'(lrpg_pkg::OneQ24)
                                   - 80'(poly + 42'(prod_now >>> 24)));
              ptr <= '0;
            end
          endcase
        end
        lrpg_pkg::ST_GRAD:
          if (ptr == n_cnt) begin
            ptr <= '0;
            if (32'(rows_seen) < MaxRows) rows_seen <= rows_seen + RowW'(1);
          end
        lrpg_pkg::ST_GRAD_WAIT: begin
          gmem[rd_addr] <= lrpg_pkg::sat48(80'(g_eff) + 80'(prod_now >>> 27));
          g_valid[rd_addr] <= 1'b1;
          ptr <= ptr + PosW'(1);
        end
        lrpg_pkg::ST_UPD:
          if (ptr == n_cnt) begin
            g_valid <= '0;
            rows_seen <= '0;
          end
        // read data for ptr is registered by now; load the divider
        lrpg_pkg::ST_LOAD: begin
          dneg   <= g_eff < 0;
          dnum   <= QW'(g_eff < 0 ? -51'(g_eff) : 51'(g_eff)) << 2;
          drem   <= '0;
          dquot  <= '0;
          dcnt   <= 6'(QW);
          drows  <= rows_div;
          w_hold <= w_eff;
        end
        lrpg_pkg::ST_DIV:
          if (dcnt != 6'd0) begin
            dcnt <= dcnt - 6'd1;
            dnum <= dnum << 1;
            if (dtrial >= (QW+1)'(drows)) begin
              drem  <= dtrial - (QW+1)'(drows);
              dquot <= {dquot[QW-2:0], 1'b1};
            end else begin
              drem  <= dtrial;
              dquot <= {dquot[QW-2:0], 1'b0};
            end
          end else begin
            out_index <= 6'(ptr);
            out_value <= lrpg_pkg::sat32(newt);
            out_last  <= (ptr + PosW'(1)) == n_cnt;
            wmem[rd_addr] <= lrpg_pkg::sat32(newt);
            w_valid[rd_addr] <= 1'b1;
          end
        lrpg_pkg::ST_EMIT: if (out_ready) ptr <= ptr + PosW'(1);
        default: ;
      endcase
    end
  end

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value))
    else $error("result dropped under stall");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    req_pop |-> state == lrpg_pkg::ST_IDLE)
    else $error("pop while busy");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= n_cnt || state == lrpg_pkg::ST_IDLE)
    else $error("pointer past row length");

endmodule

[hw/rtl/lrpg_front.sv]
// ----------------------------------------------------------------------------
// lrpg_front: input stage and coefficient registers
// Accepts requests into the queue and holds configuration.
// ----------------------------------------------------------------------------
module lrpg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrpg_pkg::req_t     in_req,
  input  logic               q_full,
  output logic               q_push,
  output lrpg_pkg::req_t     q_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] coeff_x1,
  output logic signed [31:0] coeff_x3,
  output logic signed [31:0] coeff_x5,
  output logic signed [31:0] coeff_x7
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = in_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_x1 <= lrpg_pkg::CoeffX1Reset;
      coeff_x3 <= lrpg_pkg::CoeffX3Reset;
      coeff_x5 <= '0;
      coeff_x7 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lrpg_pkg::RegCoeffX1: coeff_x1 <= cfg_data;
        lrpg_pkg::RegCoeffX3: coeff_x3 <= cfg_data;
        lrpg_pkg::RegCoeffX5: coeff_x5 <= cfg_data;
        lrpg_pkg::RegCoeffX7: coeff_x7 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[bench/lrpg_checker.sv]
// ----------------------------------------------------------------------------
// lrpg_checker: theta update predictor and result comparator
// Tracks theta writes, sample rows and coefficient writes as they are
// accepted, predicts the theta elements each batch end emits, and compares
// every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module lrpg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               ready,
  input  logic               op,
  input  logic [5:0]         index,
  input  logic signed [31:0] value,
  input  logic               last_in_row,
  input  logic               last_in_batch,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         theta_index,
  input  logic signed [31:0] theta_value,
  input  logic               last_of_run,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 64;
  localparam longint RowCap = 65536;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic               last;
  } theta_out_t;

  theta_out_t theta_q[$];

  longint cf_x1, cf_x3, cf_x5, cf_x7;
  longint theta_w[Slots];
  longint grad_acc[Slots];
  longint row_buf[Slots];
  int     row_len;
  longint row_cnt;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return clamp32((a * b) >>> 24);
  endfunction

  // Fold one accepted request into the model state; queue emitted thetas.
  task automatic absorb_request(logic r_op, logic [5:0] r_idx, longint r_val,
                                logic r_eor, logic r_eob);
    longint dot, x, x2, x3, x5, x7, poly, c, g, mag, rows;
    int n;
    theta_out_t t;
    if (r_op == lrpg_pkg::OpTheta) begin
      theta_w[r_idx] = r_val;
      return;
    end
    if (row_len < Slots) begin
      row_buf[row_len] = r_val;
      row_len++;
    end
    if (!r_eor && !r_eob) return;
    n = row_len;
    dot = 0;
    for (int i = 0; i < n; i++) dot += (row_buf[i] * theta_w[i]) >>> 24;
    x = clamp32(dot >>> 3);
    x2 = fx_mul(x, x);
    x3 = fx_mul(x2, x);
    x5 = fx_mul(x3, x2);
    x7 = fx_mul(x5, x2);
    poly = ((cf_x1 * x) >>> 24) + ((cf_x3 * x3) >>> 24)
         + ((cf_x5 * x5) >>> 24) + ((cf_x7 * x7) >>> 24);
    c = clamp32(64'sd16777216 - poly);
    for (int i = 0; i < n; i++)
      grad_acc[i] = clamp(grad_acc[i] + ((c * row_buf[i]) >>> 27),
                          -64'sd140737488355328, 64'sd140737488355327);
    if (row_cnt < RowCap) row_cnt++;
    row_len = 0;
    if (!r_eob) return;
    rows = row_cnt;
    for (int i = 0; i < n; i++) begin
      g = grad_acc[i];
      mag = (g < 0 ? -g : g) * 4 / rows;
      theta_w[i] = clamp32(theta_w[i] + (g < 0 ? -mag : mag));
      t.idx = i[5:0];
      t.val = theta_w[i][31:0];
      t.last = (i + 1 == n);
      theta_q = {theta_q, t};
    end
    for (int i = 0; i < Slots; i++) grad_acc[i] = 0;
    row_cnt = 0;
  endtask

  always @(posedge clk) begin
    theta_out_t e;
    if (rst) begin
      cf_x1 = lrpg_pkg::CoeffX1Reset;
      cf_x3 = lrpg_pkg::CoeffX3Reset;
      cf_x5 = 0;
      cf_x7 = 0;
      for (int i = 0; i < Slots; i++) begin
        theta_w[i] = 0;
        grad_acc[i] = 0;
        row_buf[i] = 0;
      end
      row_len = 0;
      row_cnt = 0;
      theta_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lrpg_pkg::RegCoeffX1: cf_x1 = $signed(cfg_data);
          lrpg_pkg::RegCoeffX3: cf_x3 = $signed(cfg_data);
          lrpg_pkg::RegCoeffX5: cf_x5 = $signed(cfg_data);
          lrpg_pkg::RegCoeffX7: cf_x7 = $signed(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (theta_q.size() == 0) begin
          $display("%0t: unexpected theta result idx %0d value %0d", $time,
                   theta_index, theta_value);
          errors++;
        end else begin
          e = theta_q.pop_front();
          if (theta_index !== e.idx) begin
            $display("%0t: theta_index expected %0d actual %0d", $time,
                     e.idx, theta_index);
            errors++;
          end
          if (theta_value !== e.val) begin
            $display("%0t: theta_value[%0d] expected %0d actual %0d", $time,
                     e.idx, e.val, theta_value);
            errors++;
          end
          if (last_of_run !== e.last) begin
            $display("%0t: last_of_run[%0d] expected %0b actual %0b", $time,
                     e.idx, e.last, last_of_run);
            errors++;
          end
        end
      end
      if (valid && ready)
        absorb_request(op, index, longint'(value), last_in_row, last_in_batch);
    end
    pending = theta_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: polynomial logistic-regression gradient step testbench
// Drives theta writes and sample batches under bursty input and a stalling
// receiver, across several coefficient sets; a checker predicts every
// emitted theta element and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               valid = 1'b0;
  logic               ready;
  logic               op = lrpg_pkg::OpTheta;
  logic [5:0]         index = '0;
  logic signed [31:0] value = '0;
  logic               last_in_row = 1'b0;
  logic               last_in_batch = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [5:0]         theta_index;
  logic signed [31:0] theta_value;
  logic               last_of_run;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int errors;
  int pending;
  int sent = 0;
  int burst_left = 0;

  // Receiver stall pattern state
  int stall_mode = 0;
  int stall_span = 0;
  int cyc = 0;

  always #5 clk = ~clk;

  logistic_regression_poly_gradient_step u_dut (
    .clk, .rst, .valid, .ready, .op, .index, .value, .last_in_row,
    .last_in_batch, .out_valid, .out_ready, .theta_index, .theta_value,
    .last_of_run, .cfg_we, .cfg_index, .cfg_data
  );

  lrpg_checker u_chk (
    .clk, .rst, .valid, .ready, .op, .index, .value, .last_in_row,
    .last_in_batch, .out_valid, .out_ready, .theta_index, .theta_value,
    .last_of_run, .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // Receiver: switch between always ready, coin flips, a 3-of-4 pattern and
  // hard stalls, each held for a random span.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(5, 60);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (cyc % 4) != 0;
      default: out_ready <= 1'b0;
    endcase
  end

  // Pick a value: mostly near unity so the polynomial stays in range,
  // sometimes full scale or a rail to hit saturation.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  // Present one request and hold it until accepted. Between bursts, drop
  // valid for a random gap.
  task automatic send_req(logic r_op, logic [5:0] r_idx, logic [31:0] r_val,
                          logic r_eor, logic r_eob);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 120)
                                              : $urandom_range(1, 20);
    end
    burst_left--;
    valid <= 1'b1;
    op <= r_op;
    index <= r_idx;
    value <= r_val;
    last_in_row <= r_eor;
    last_in_batch <= r_eob;
    do @(posedge clk); while (!ready);
    sent++;
  endtask

  task automatic go_idle();
    valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a row end produces nothing, but keeps the back end busy for a while
    repeat (400) @(posedge clk);
  endtask

  task automatic write_coeffs(logic [31:0] c1, logic [31:0] c3,
                              logic [31:0] c5, logic [31:0] c7);
    logic [31:0] vals[4];
    vals = '{c1, c3, c5, c7};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed batch with random content: a few theta writes, then rows.
  // Mostly short rows; now and then a full or overlong one.
  task automatic send_batch();
    int nrows, len, sel;
    logic eob;
    repeat ($urandom_range(0, 4))
      send_req(lrpg_pkg::OpTheta, 6'($urandom_range(0, 63)), pick_value(),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    nrows = $urandom_range(1, 3);
    for (int r = 0; r < nrows; r++) begin
      sel = $urandom_range(0, 19);
      len = sel == 0 ? $urandom_range(64, 70)
          : sel < 3 ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        eob = (r == nrows - 1) && (k == len - 1);
        if (k != len - 1)
          send_req(lrpg_pkg::OpSample, 6'($urandom), pick_value(), 1'b0, 1'b0);
        else if (eob)
          // the batch end alone also closes the row
          send_req(lrpg_pkg::OpSample, 6'($urandom), pick_value(),
                   1'($urandom_range(0, 1)), 1'b1);
        else
          send_req(lrpg_pkg::OpSample, 6'($urandom), pick_value(), 1'b1, 1'b0);
      end
    end
  endtask

  // Random traffic until the phase's share of items has gone out, then
  // close any open batch so all its results land.
  task automatic random_phase(int quota);
    int stop_at;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_req(1'($urandom_range(0, 1)), 6'($urandom), pick_value(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        send_batch();
    end
    send_req(lrpg_pkg::OpSample, '0, pick_value(), 1'b1, 1'b1);
    go_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: theta writes at both ends of the index and value range,
    // flags set on a theta write, an empty-theta batch.
    send_req(lrpg_pkg::OpTheta, 6'd0, 32'h0100_0000, 1'b1, 1'b1);
    send_req(lrpg_pkg::OpTheta, 6'd1, 32'h8000_0000, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpTheta, 6'd63, 32'h7fff_ffff, 1'b0, 1'b1);
    send_req(lrpg_pkg::OpTheta, 6'd2, 32'hff00_0000, 1'b1, 1'b0);
    // two-row batch with rail values
    send_req(lrpg_pkg::OpSample, 6'd0, 32'h7fff_ffff, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd0, 32'h8000_0000, 1'b1, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd0, 32'h0100_0000, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd0, 32'h0000_0000, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd0, 32'hffff_ffff, 1'b1, 1'b1);
    // batch end without a row end, three features
    send_req(lrpg_pkg::OpSample, 6'd63, 32'h0080_0000, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd5, 32'hff80_0000, 1'b0, 1'b0);
    send_req(lrpg_pkg::OpSample, 6'd9, 32'h0200_0000, 1'b0, 1'b1);
    // single-element batch
    send_req(lrpg_pkg::OpSample, 6'd0, 32'h8000_0000, 1'b1, 1'b1);
    go_idle();

    random_phase(110);

    // degree-7 coefficient set
    write_coeffs(32'd58215597, -32'sd140729637, 32'd182335455, -32'sd83886080);
    random_phase(110);

    // rails on every coefficient
    write_coeffs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    random_phase(110);

    write_coeffs(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    random_phase(60);

    // random coefficients, mostly near unity
    write_coeffs(pick_value(), pick_value(), pick_value(), pick_value());
    random_phase(60);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
